// ----- hdl/ellipse_point_generator_top_assert.svh -----
// Assertion macros used by the ellipse point generator engine.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ELLIPSE_POINT_GENERATOR_TOP_ASSERT_SVH
`define ELLIPSE_POINT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define EPG_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define EPG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/epg_pkg.sv -----
// Package for the ellipse point generator: opcode enum, stage control struct,
// default coordinate width. No dependencies.
package epg_pkg;

  localparam int unsigned EPG_COORD_BITS = 12;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } epg_op_e;

  // Control for the word held in the input stage.
  typedef struct packed {
    logic    valid;
    epg_op_e op;
  } epg_stage_t;

endpackage

// ----- hdl/epg_prep.sv -----
// Input stage of the ellipse point generator: squares the radii and registers
// the incoming word. Depends on epg_pkg.
module epg_prep #(
  parameter int unsigned COORD_BITS = epg_pkg::EPG_COORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [COORD_BITS-1:0]       center_x_i,
  input  logic [COORD_BITS-1:0]       center_y_i,
  input  logic [COORD_BITS-2:0]       radius_x_i,
  input  logic [COORD_BITS-2:0]       radius_y_i,
  input  logic                        take_i,
  output epg_pkg::epg_stage_t         stage_o,
  output logic [COORD_BITS-1:0]       center_x_o,
  output logic [COORD_BITS-1:0]       center_y_o,
  output logic [COORD_BITS-2:0]       radius_y_o,
  output logic [2*COORD_BITS-3:0]     rx_sq_o,
  output logic [2*COORD_BITS-3:0]     ry_sq_o
);
  import epg_pkg::*;

  localparam int unsigned RAD_BITS = COORD_BITS - 1;
  localparam int unsigned SQ_BITS  = 2 * RAD_BITS;

  logic                  valid_q, valid_d;
  epg_op_e               op_q;
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [RAD_BITS-1:0]   ry_q;
  logic [SQ_BITS-1:0]    rx_sq_q, ry_sq_q, rx_sq_d, ry_sq_d;
  logic                  accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign rx_sq_d = {{RAD_BITS{1'b0}}, radius_x_i} * {{RAD_BITS{1'b0}}, radius_x_i};
  assign ry_sq_d = {{RAD_BITS{1'b0}}, radius_y_i} * {{RAD_BITS{1'b0}}, radius_y_i};

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= epg_op_e'(opcode_i);
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      ry_q    <= radius_y_i;
      rx_sq_q <= rx_sq_d;
      ry_sq_q <= ry_sq_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.op    = op_q;
  assign center_x_o    = cx_q;
  assign center_y_o    = cy_q;
  assign radius_y_o    = ry_q;
  assign rx_sq_o       = rx_sq_q;
  assign ry_sq_o       = ry_sq_q;

endmodule

// ----- hdl/epg_engine.sv -----
// Stepping engine of the ellipse point generator: ellipse state, incremental
// error update, mirrored points and result register. Depends on epg_pkg and the assertion header.
`include "ellipse_point_generator_top_assert.svh"

module epg_engine #(
  parameter int unsigned COORD_BITS = epg_pkg::EPG_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  epg_pkg::epg_stage_t           stage_i,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [COORD_BITS-1:0]         center_y_i,
  input  logic [COORD_BITS-2:0]         radius_y_i,
  input  logic [2*COORD_BITS-3:0]       rx_sq_i,
  input  logic [2*COORD_BITS-3:0]       ry_sq_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          point_valid_o,
  output logic                          last_step_o,
  output logic signed [COORD_BITS+1:0]  right_lower_x_o,
  output logic signed [COORD_BITS+1:0]  right_lower_y_o,
  output logic signed [COORD_BITS+1:0]  left_lower_x_o,
  output logic signed [COORD_BITS+1:0]  left_lower_y_o,
  output logic signed [COORD_BITS+1:0]  right_upper_x_o,
  output logic signed [COORD_BITS+1:0]  right_upper_y_o,
  output logic signed [COORD_BITS+1:0]  left_upper_x_o,
  output logic signed [COORD_BITS+1:0]  left_upper_y_o
);
  import epg_pkg::*;

  localparam int unsigned RAD_BITS = COORD_BITS - 1;
  localparam int unsigned SQ_BITS  = 2 * RAD_BITS;
  localparam int unsigned Y_BITS   = COORD_BITS + 1;
  localparam int unsigned OUT_BITS = COORD_BITS + 2;
  localparam int unsigned ERR_BITS = 3 * RAD_BITS + 7;
  localparam int unsigned PRD_BITS = SQ_BITS + RAD_BITS + 3;

  // ellipse state
  logic                       busy_q, busy_d;
  logic [COORD_BITS-1:0]      x_q, x_d;
  logic signed [Y_BITS-1:0]   y_q, y_d;
  logic signed [ERR_BITS-1:0] e_q, e_d;
  logic signed [ERR_BITS-1:0] ay_q, ay_d;   // rx^2 * (3 - 2y): error gain on y--
  logic signed [ERR_BITS-1:0] bx_q, bx_d;   // ry^2 * (2x + 3): error gain on x++
  logic [SQ_BITS-1:0]         a2_q, a2_d, b2_q, b2_d;
  logic [COORD_BITS-1:0]      ox_q, ox_d, oy_q, oy_d;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic                       pv_q, pv_d, last_q, last_d;
  logic signed [OUT_BITS-1:0] rlx_q, rly_q, llx_q, lly_q, rux_q, ruy_q, lux_q, luy_q;
  logic signed [OUT_BITS-1:0] rlx_d, rly_d, llx_d, lly_d, rux_d, ruy_d, lux_d, luy_d;

  logic move, is_start, is_step;

  // start setup
  logic signed [SQ_BITS:0]      a2_in_s;
  logic signed [RAD_BITS+1:0]   two_ry_m1;
  logic signed [PRD_BITS-1:0]   prod;
  logic signed [ERR_BITS-1:0]   m_init, a2_in_e, b2_in_e;

  // step terms
  logic signed [ERR_BITS-1:0]   a2_e, b2_e, t_lo, t_hi, e_step;
  logic                         inc_x, dec_y;
  logic [COORD_BITS-1:0]        x_step;
  logic signed [Y_BITS-1:0]     y_step;
  logic signed [OUT_BITS-1:0]   x_ext, y_ext, ox_ext, oy_ext;

  assign take_o   = !out_valid_q || !out_stall_i;
  assign move     = take_o && stage_i.valid;
  assign is_start = stage_i.op == OP_START;
  assign is_step  = stage_i.op == OP_STEP;

  // start: e = ry^2 - rx^2(2ry-1), ay = 2rx^2 - rx^2(2ry-1), bx = 3ry^2
  assign a2_in_s   = signed'({1'b0, rx_sq_i});
  assign two_ry_m1 = signed'({1'b0, radius_y_i, 1'b0}) - signed'((RAD_BITS + 2)'(1));
  assign prod      = a2_in_s * two_ry_m1;
  assign m_init    = ERR_BITS'(prod);
  assign a2_in_e   = signed'(ERR_BITS'(rx_sq_i));
  assign b2_in_e   = signed'(ERR_BITS'(ry_sq_i));

  // step decision with incremental gain registers, no multiply in the loop
  assign a2_e = signed'(ERR_BITS'(a2_q));
  assign b2_e = signed'(ERR_BITS'(b2_q));
  assign t_lo = (e_q <<< 1) + (a2_e <<< 2) - ay_q;           // 2e + rx^2(2y+1)
  assign t_hi = (e_q <<< 1) + (b2_e <<< 2) + b2_e - bx_q;    // 2e + ry^2(2-2x)

  always_comb begin
    if (e_q[ERR_BITS-1]) begin
      inc_x = 1'b1;
      dec_y = !t_lo[ERR_BITS-1];
    end else if (e_q != '0) begin
      dec_y = 1'b1;
      inc_x = t_hi[ERR_BITS-1] || (t_hi == '0);
    end else begin
      inc_x = 1'b1;
      dec_y = 1'b1;
    end
  end

  assign e_step = e_q + (inc_x ? bx_q : '0) + (dec_y ? ay_q : '0);
  assign x_step = x_q + COORD_BITS'(inc_x);
  assign y_step = y_q - (dec_y ? signed'(Y_BITS'(1)) : signed'(Y_BITS'(0)));

  assign x_ext  = signed'(OUT_BITS'(x_q));
  assign ox_ext = signed'(OUT_BITS'(ox_q));
  assign oy_ext = signed'(OUT_BITS'(oy_q));
  assign y_ext  = OUT_BITS'(y_q);

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    e_d    = e_q;
    ay_d   = ay_q;
    bx_d   = bx_q;
    a2_d   = a2_q;
    b2_d   = b2_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    pv_d   = 1'b0;
    last_d = 1'b0;
    rlx_d  = '0;
    rly_d  = '0;
    llx_d  = '0;
    lly_d  = '0;
    rux_d  = '0;
    ruy_d  = '0;
    lux_d  = '0;
    luy_d  = '0;
    if (is_start) begin
      busy_d = 1'b1;
      x_d    = '0;
      y_d    = signed'(Y_BITS'(radius_y_i));
      e_d    = b2_in_e - m_init;
      ay_d   = (a2_in_e <<< 1) - m_init;
      bx_d   = (b2_in_e <<< 1) + b2_in_e;
      a2_d   = rx_sq_i;
      b2_d   = ry_sq_i;
      ox_d   = center_x_i;
      oy_d   = center_y_i;
    end else if (is_step && busy_q) begin
      x_d    = x_step;
      y_d    = y_step;
      e_d    = e_step;
      ay_d   = dec_y ? ay_q + (a2_e <<< 1) : ay_q;
      bx_d   = inc_x ? bx_q + (b2_e <<< 1) : bx_q;
      busy_d = !y_step[Y_BITS-1];
      pv_d   = 1'b1;
      last_d = y_step[Y_BITS-1];
      rlx_d  = ox_ext + x_ext;
      rly_d  = oy_ext + y_ext;
      llx_d  = ox_ext - x_ext;
      lly_d  = oy_ext + y_ext;
      rux_d  = ox_ext + x_ext;
      ruy_d  = oy_ext - y_ext;
      lux_d  = ox_ext - x_ext;
      luy_d  = oy_ext - y_ext;
    end
  end

  always_comb begin
    if (take_o) begin
      out_valid_d = stage_i.valid;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (move) begin
        busy_q <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      x_q    <= x_d;
      y_q    <= y_d;
      e_q    <= e_d;
      ay_q   <= ay_d;
      bx_q   <= bx_d;
      a2_q   <= a2_d;
      b2_q   <= b2_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      pv_q   <= pv_d;
      last_q <= last_d;
      rlx_q  <= rlx_d;
      rly_q  <= rly_d;
      llx_q  <= llx_d;
      lly_q  <= lly_d;
      rux_q  <= rux_d;
      ruy_q  <= ruy_d;
      lux_q  <= lux_d;
      luy_q  <= luy_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign point_valid_o   = pv_q;
  assign last_step_o     = last_q;
  assign right_lower_x_o = rlx_q;
  assign right_lower_y_o = rly_q;
  assign left_lower_x_o  = llx_q;
  assign left_lower_y_o  = lly_q;
  assign right_upper_x_o = rux_q;
  assign right_upper_y_o = ruy_q;
  assign left_upper_x_o  = lux_q;
  assign left_upper_y_o  = luy_q;

  `EPG_ASSERT_NOW(a_last_is_valid, out_valid_q && last_q, pv_q, "last step without valid points")
  `EPG_ASSERT_NOW(a_busy_y_nonneg, busy_q, !y_q[Y_BITS-1], "active ellipse with negative y")
  `EPG_ASSERT_NEXT(a_start_invalid, move && is_start, out_valid_q && !pv_q && busy_q, "start word produced points or left engine idle")
  `EPG_ASSERT_NOW(a_end_marked, $fell(busy_q), out_valid_q && last_q, "ellipse ended without last step")

endmodule

// ----- hdl/ellipse_point_generator_top.sv -----
// Top level of the ellipse point generator.
// Depends on epg_pkg, epg_prep and epg_engine.
//
// Ellipse point generator, Bresenham error-term rasterization. A start word
// (opcode 0) loads center and radii and yields an all-zero invalid result; each
// step word (opcode 1) yields the four points mirrored about the center for the
// current offset, then moves the offset. The step on which y drops below zero
// carries last_step; step words outside an ellipse give all-zero results.
// A start while an ellipse runs replaces it. Every input word gives exactly one
// result word. Throughput is one word per clock while out_stall_i is low; the
// radius squares are formed ahead of the input register, the engine works
// between that register and the result register. The per-step error loop is
// adders only: the x and y gain terms are kept as registers and bumped by
// twice the squared radius on each move. Past the two radius squarers the only
// multiplier (squared horizontal radius times 2*ry-1) sits on the start path.
// While a result is held by a stall an empty input register still takes one
// more word.
module ellipse_point_generator_top #(
  parameter int unsigned COORD_BITS = epg_pkg::EPG_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [COORD_BITS-1:0]         center_y_i,
  input  logic [COORD_BITS-2:0]         radius_x_i,
  input  logic [COORD_BITS-2:0]         radius_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          point_valid_o,
  output logic                          last_step_o,
  output logic signed [COORD_BITS+1:0]  right_lower_x_o,
  output logic signed [COORD_BITS+1:0]  right_lower_y_o,
  output logic signed [COORD_BITS+1:0]  left_lower_x_o,
  output logic signed [COORD_BITS+1:0]  left_lower_y_o,
  output logic signed [COORD_BITS+1:0]  right_upper_x_o,
  output logic signed [COORD_BITS+1:0]  right_upper_y_o,
  output logic signed [COORD_BITS+1:0]  left_upper_x_o,
  output logic signed [COORD_BITS+1:0]  left_upper_y_o
);
  import epg_pkg::*;

  localparam int unsigned RAD_BITS = COORD_BITS - 1;
  localparam int unsigned SQ_BITS  = 2 * RAD_BITS;

  epg_stage_t            stage;
  logic [COORD_BITS-1:0] cx, cy;
  logic [RAD_BITS-1:0]   ry;
  logic [SQ_BITS-1:0]    rx_sq, ry_sq;
  logic                  take;

  // input register with radius squaring
  epg_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_x_i (radius_x_i),
    .radius_y_i (radius_y_i),
    .take_i     (take),
    .stage_o    (stage),
    .center_x_o (cx),
    .center_y_o (cy),
    .radius_y_o (ry),
    .rx_sq_o    (rx_sq),
    .ry_sq_o    (ry_sq)
  );

  // ellipse state, stepping logic and result register
  epg_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .center_x_i      (cx),
    .center_y_i      (cy),
    .radius_y_i      (ry),
    .rx_sq_i         (rx_sq),
    .ry_sq_i         (ry_sq),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .point_valid_o   (point_valid_o),
    .last_step_o     (last_step_o),
    .right_lower_x_o (right_lower_x_o),
    .right_lower_y_o (right_lower_y_o),
    .left_lower_x_o  (left_lower_x_o),
    .left_lower_y_o  (left_lower_y_o),
    .right_upper_x_o (right_upper_x_o),
    .right_upper_y_o (right_upper_y_o),
    .left_upper_x_o  (left_upper_x_o),
    .left_upper_y_o  (left_upper_y_o)
  );

endmodule

// ----- verif/epg_tb_pkg.sv -----
// Checking side of the ellipse point generator bench: an ellipse tracker that
// predicts each result word and compares it with what the block returns.
// Depends on epg_pkg for the opcode enum and the default coordinate width.
package epg_tb_pkg;
  import epg_pkg::*;

  typedef logic signed [EPG_COORD_BITS+1:0] coord_t;

  // One result word: flags plus the four mirrored points, x and y interleaved
  // in port order.
  typedef struct {
    logic   point_valid;
    logic   last_step;
    coord_t coord [8];
  } point_set_t;

  class ellipse_tracker;
    bit         active;
    longint     off_x, off_y, err;
    longint     rx_sq, ry_sq, org_x, org_y;
    point_set_t expected_points [$];
    int unsigned errors, checked, finished_ellipses, stray_steps;
    string coord_name [8] = '{"right_lower_x", "right_lower_y", "left_lower_x",
                              "left_lower_y", "right_upper_x", "right_upper_y",
                              "left_upper_x", "left_upper_y"};

    // Accepted input word: work out the result it causes and queue it.
    function void take_word(epg_op_e op, logic [EPG_COORD_BITS-1:0] cx,
                            logic [EPG_COORD_BITS-1:0] cy, logic [EPG_COORD_BITS-2:0] rx,
                            logic [EPG_COORD_BITS-2:0] ry);
      point_set_t ps;
      longint     x, y, e, t;
      ps.point_valid = 1'b0;
      ps.last_step   = 1'b0;
      foreach (ps.coord[k]) ps.coord[k] = '0;
      if (op == OP_START) begin
        org_x  = longint'(cx);
        org_y  = longint'(cy);
        rx_sq  = longint'(rx) * longint'(rx);
        ry_sq  = longint'(ry) * longint'(ry);
        off_x  = 0;
        off_y  = longint'(ry);
        err    = ry_sq - rx_sq * (2 * off_y - 1);
        active = 1'b1;
      end else if (active) begin
        x = off_x;
        y = off_y;
        e = err;
        ps.point_valid = 1'b1;
        ps.coord[0] = coord_t'(org_x + x);
        ps.coord[1] = coord_t'(org_y + y);
        ps.coord[2] = coord_t'(org_x - x);
        ps.coord[3] = coord_t'(org_y + y);
        ps.coord[4] = coord_t'(org_x + x);
        ps.coord[5] = coord_t'(org_y - y);
        ps.coord[6] = coord_t'(org_x - x);
        ps.coord[7] = coord_t'(org_y - y);
        // three-way error rule: horizontal, vertical or diagonal move
        if (e < 0) begin
          t = 2 * e + rx_sq * (2 * y + 1);
          x += 1;
          if (t < 0) begin
            e += ry_sq * (2 * x + 1);
          end else begin
            y -= 1;
            e += ry_sq * (2 * x + 1) + rx_sq * (1 - 2 * y);
          end
        end else if (e > 0) begin
          t = 2 * e + ry_sq * (2 - 2 * x);
          y -= 1;
          if (t > 0) begin
            e += rx_sq * (1 - 2 * y);
          end else begin
            x += 1;
            e += ry_sq * (2 * x + 1) + rx_sq * (1 - 2 * y);
          end
        end else begin
          y -= 1;
          x += 1;
          e += ry_sq * (2 * x + 1) + rx_sq * (1 - 2 * y);
        end
        off_x = x;
        off_y = y;
        err   = e;
        if (y < 0) begin
          ps.last_step = 1'b1;
          active       = 1'b0;
          finished_ellipses++;
        end
      end else begin
        stray_steps++;
      end
      expected_points.push_back(ps);
    endfunction

    // Accepted result word: compare field by field with the oldest prediction.
    function void check_points(point_set_t got, realtime now);
      point_set_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: result word with nothing predicted, point_valid %0b",
                 now, got.point_valid);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      checked++;
      if (got.point_valid !== want.point_valid) begin
        $display("%0t: point_valid expected %0b, actual %0b", now, want.point_valid,
                 got.point_valid);
        errors++;
      end
      if (got.last_step !== want.last_step) begin
        $display("%0t: last_step expected %0b, actual %0b", now, want.last_step,
                 got.last_step);
        errors++;
      end
      foreach (want.coord[k]) begin
        if (got.coord[k] !== want.coord[k]) begin
          $display("%0t: %s expected %0d, actual %0d", now, coord_name[k], want.coord[k],
                   got.coord[k]);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

// ----- verif/tb_ellipse_point_generator_top.sv -----
// Bench for ellipse_point_generator_top: drives start and step words with
// random gaps and stalls and checks every result word against a prediction.
// Depends on epg_pkg, epg_tb_pkg and the block's RTL.
module tb_ellipse_point_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import epg_pkg::*;
  import epg_tb_pkg::*;

  localparam int unsigned CB             = EPG_COORD_BITS;
  localparam int unsigned TARGET_WORDS   = 850;
  // receiver hold-off that backs the pipeline up into the input side
  localparam int unsigned SQUEEZE_CYCLES = 200;
  // cycles with no word moving on either side before the run is called hung;
  // the longest legal quiet stretch is the hold-off plus the sender's random gaps
  localparam int unsigned WATCHDOG_LIMIT = 5 * SQUEEZE_CYCLES;
  // margin left after the last result
  localparam int unsigned DRAIN_CYCLES   = 8;

  // Every input starts at a known value; reset is held from time zero.
  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          opcode_i    = 1'b0;
  logic [CB-1:0] center_x_i  = '0;
  logic [CB-1:0] center_y_i  = '0;
  logic [CB-2:0] radius_x_i  = '0;
  logic [CB-2:0] radius_y_i  = '0;
  logic          out_stall_i = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  logic          point_valid_o;
  logic          last_step_o;
  coord_t        right_lower_x_o, right_lower_y_o, left_lower_x_o, left_lower_y_o;
  coord_t        right_upper_x_o, right_upper_y_o, left_upper_x_o, left_upper_y_o;

  ellipse_tracker tracker = new();

  bit          idle_on     = 1'b1;  // random gaps and stalls allowed
  bit          squeeze_req = 1'b0;  // asks the receiver for one long hold-off
  int unsigned words_sent  = 0;
  int unsigned idle_cycles = 0;

  ellipse_point_generator_top DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor. Runs on the rising edge and reads the values that held just
  // before it, so the handshake seen here is the one the block saw. The input
  // word is noted before the result is checked, so a result can never race
  // ahead of its own prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    point_set_t got;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        tracker.take_word(epg_op_e'(opcode_i), center_x_i, center_y_i, radius_x_i,
                          radius_y_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.point_valid = point_valid_o;
        got.last_step   = last_step_o;
        got.coord[0]    = right_lower_x_o;
        got.coord[1]    = right_lower_y_o;
        got.coord[2]    = left_lower_x_o;
        got.coord[3]    = left_lower_y_o;
        got.coord[4]    = right_upper_x_o;
        got.coord[5]    = right_upper_y_o;
        got.coord[6]    = left_upper_x_o;
        got.coord[7]    = left_upper_y_o;
        tracker.check_points(got, $realtime);
        moved = 1'b1;
      end
      // watchdog: a hung handshake ends the run here
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
        $display("tb_ellipse_point_generator_top: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Stalls with odds of 27 in a hundred while idling is on. Once per
  // run it holds stall high for a long stretch on its own count, so the result
  // register and the input register both fill and in_stall_o rises while the
  // sender keeps offering words.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= idle_on && ($urandom_range(99) < 27);
    end
  end

  // One input word. Entered and left on a falling edge. A gap lowers valid
  // first; otherwise valid stays high into the next word. The payload holds
  // until the word is taken.
  task automatic send_word(input epg_op_e op, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-2:0] rx,
                           input logic [CB-2:0] ry);
    if (idle_on && ($urandom_range(99) < 27)) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 27);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_x_i <= rx;
    radius_y_i <= ry;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Start word followed by a run of step words. Step payloads are ignored by
  // the block, so they carry random bits.
  task automatic run_ellipse(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                             input logic [CB-2:0] rx, input logic [CB-2:0] ry,
                             input int unsigned steps);
    send_word(OP_START, cx, cy, rx, ry);
    repeat (steps) begin
      send_word(OP_STEP, (CB)'($urandom), (CB)'($urandom), (CB-1)'($urandom),
                (CB-1)'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned   pick;
    logic [CB-2:0] rx, ry;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed ---
    // step with no ellipse running: all-zero invalid result
    send_word(OP_STEP, '1, '1, '1, '1);
    // largest radii at both corners of the center range
    run_ellipse('1, '1, '1, '1, 2);
    run_ellipse('0, '0, '1, '1, 2);
    // both radii zero: one step at the center, then a stray step
    run_ellipse('0, '0, '0, '0, 2);
    // zero vertical radius: single step
    run_ellipse(12'd2048, 12'd1024, 11'd5, 11'd0, 2);
    // zero horizontal radius: straight vertical run
    run_ellipse(12'd17, 12'd4000, 11'd0, 11'd3, 5);
    // start while an ellipse is running replaces it
    run_ellipse(12'd300, 12'd300, 11'd3, 11'd2, 1);
    run_ellipse(12'd100, 12'd200, 11'd2, 11'd1, 4);

    // --- random ---
    squeeze_req = 1'b1;
    while (words_sent < TARGET_WORDS) begin
      // a quiet stretch with neither side idling
      idle_on = !(words_sent >= 350 && words_sent < 500);
      pick = $urandom_range(99);
      if (pick < 70) begin
        // small ellipse run to its last step, padded with stray steps to rx + ry + 2 to rx + ry + 4 steps
        rx = (CB-1)'($urandom_range(15));
        ry = (CB-1)'($urandom_range(15));
        run_ellipse((CB)'($urandom), (CB)'($urandom), rx, ry,
                    int'(rx) + int'(ry) + 2 + $urandom_range(2));
      end else if (pick < 80) begin
        // mid-size ellipse given up to rx + ry steps, so the next start may cut it short
        rx = (CB-1)'($urandom_range(63));
        ry = (CB-1)'($urandom_range(63));
        run_ellipse((CB)'($urandom), (CB)'($urandom), rx, ry,
                    $urandom_range(int'(rx) + int'(ry)));
      end else if (pick < 86) begin
        // full-range radii, only the first few steps
        run_ellipse((CB)'($urandom), (CB)'($urandom), (CB-1)'($urandom),
                    (CB-1)'($urandom), $urandom_range(1, 6));
      end else begin
        // single word of either kind
        send_word(epg_op_e'($urandom_range(1)), (CB)'($urandom), (CB)'($urandom),
                  (CB-1)'($urandom), (CB-1)'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    // drain: the watchdog covers a result that never comes
    while (tracker.expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d words in, %0d results compared, %0d mismatches", words_sent,
             tracker.checked, tracker.errors);
    $display("run: %0d ellipses traced to their last step, %0d steps with none active",
             tracker.finished_ellipses, tracker.stray_steps);
    if (tracker.errors == 0 && tracker.expected_points.size() == 0) begin
      $display("tb_ellipse_point_generator_top: done, clean");
    end else begin
      $display("tb_ellipse_point_generator_top: done, errors");
    end
    $finish;
  end

endmodule
